@@ hw/rtl/vertex_view_transform_project_assert.svh @@
// Assertion macros shared by the checker of the vertex view transform.
// Each macro expects a signal clk, and all but VVT_ASSERT_ALWAYS also rst_n.
`ifndef VERTEX_VIEW_TRANSFORM_PROJECT_ASSERT_SVH
`define VERTEX_VIEW_TRANSFORM_PROJECT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VVT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VVT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// No reset gating, for checks that look at the reset itself.
`define VVT_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

@@ hw/rtl/vvt_pkg.sv @@
// Package of the vertex view transform: widths, screen constants, register
// indexes and the structs passed between pipeline modules. No dependencies.
`default_nettype none
package vvt_pkg;

  localparam int SCREEN_WIDTH  = 800;
  localparam int SCREEN_HEIGHT = 600;

  localparam int FRAC_BITS = 14;  // fraction bits of the sine and cosine values
  localparam int DIFF_W    = 33;  // vertex minus camera
  localparam int ROT_W     = 36;  // after the heading rotation
  localparam int FIN_W     = 39;  // after the pitch rotation
  localparam int DEN_W     = FIN_W;
  localparam int NUM_W     = 56;  // projection numerator and remainder
  localparam int Q_BITS    = 15;  // quotient magnitude bits below saturation

  localparam logic signed [NUM_W-1:0] SCR_W_N  = NUM_W'(SCREEN_WIDTH);
  localparam logic signed [NUM_W-1:0] SCR_2W_N = NUM_W'(2 * SCREEN_WIDTH);
  localparam logic signed [NUM_W-1:0] SCR_H_N  = NUM_W'(SCREEN_HEIGHT);

  localparam logic signed [15:0] SCREEN_MAX = 16'sh7fff;
  localparam logic signed [15:0] SCREEN_MIN = 16'sh8000;
  localparam logic signed [31:0] DEPTH_MAX  = 32'sh7fffffff;
  localparam logic signed [31:0] DEPTH_MIN  = 32'sh80000000;

  typedef enum logic [2:0] {
    CFG_CAMERA_X       = 3'd0,
    CFG_CAMERA_Y       = 3'd1,
    CFG_CAMERA_Z       = 3'd2,
    CFG_HEADING_SINE   = 3'd3,
    CFG_HEADING_COSINE = 3'd4,
    CFG_PITCH_SINE     = 3'd5,
    CFG_PITCH_COSINE   = 3'd6,
    CFG_NEAR_DISTANCE  = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic signed [31:0] cam_x;
    logic signed [31:0] cam_y;
    logic signed [31:0] cam_z;
    logic signed [15:0] hs;
    logic signed [15:0] hc;
    logic signed [15:0] ps;
    logic signed [15:0] pc;
    logic [30:0]        near;
  } cam_cfg_t;

  typedef struct packed {
    logic             neg;
    logic             sat;
    logic [NUM_W-1:0] rem;
  } div_lane_t;

  typedef struct packed {
    logic               behind;
    logic signed [31:0] depth;
  } vtx_side_t;

endpackage
`default_nettype wire

@@ hw/rtl/vertex_view_transform_project.sv @@
// Top level of the vertex view transform: configuration registers, pipeline
// control and the output register. Depends on vvt_pkg, vvt_rotate,
// vvt_setup and vvt_divide.
`default_nettype none
// One world-space vertex request (signed Q16.16) enters per clock cycle and
// its result passes through the pipeline in order: five stages translate and
// rotate the vertex, two form the near-plane test and the projection
// numerators, fifteen stages each resolve one quotient bit of the two
// divisions by depth, and a last stage registers the saturated screen
// coordinates. The rate is one vertex per cycle whenever the output is
// taken. When the result request is not taken, the whole
// pipeline holds its contents and in_ready drops; nothing is lost or
// repeated. behind_near is set when the depth falls below near_distance or
// is zero, and the screen coordinates are then zero; a triangle is to be
// rejected downstream when any of its vertices has the flag set. Write the
// configuration registers only while no request is in flight.
module vertex_view_transform_project
  import vvt_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] in_vertex_x,
  input  wire logic signed [31:0] in_vertex_y,
  input  wire logic signed [31:0] in_vertex_z,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      out_screen_x,
  output logic signed [15:0]      out_screen_y,
  output logic signed [31:0]      out_view_depth,
  output logic                    out_behind_near,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_wdata
);

  cam_cfg_t cfg_r;
  logic     en;

  logic                    rot_valid;
  logic signed [ROT_W-1:0] rot_rx;
  logic signed [FIN_W-1:0] rot_fy, rot_fz;

  logic             set_valid;
  logic [DEN_W-1:0] set_den;
  div_lane_t        set_lx, set_ly;
  vtx_side_t        set_side;

  logic              div_valid;
  logic [Q_BITS-1:0] div_qx, div_qy;
  div_lane_t         div_fx, div_fy;
  vtx_side_t         div_side;

  logic                out_valid_r;
  logic signed [15:0]  sx_r, sy_r, sx_nxt, sy_nxt;
  logic signed [31:0]  depth_r;
  logic                behind_r;

  // The whole pipeline advances together whenever the output slot is free
  // or being emptied in this cycle.
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cam_x <= '0;
      cfg_r.cam_y <= '0;
      cfg_r.cam_z <= '0;
      cfg_r.hs    <= 16'sd16384;
      cfg_r.hc    <= '0;
      cfg_r.ps    <= '0;
      cfg_r.pc    <= 16'sd16384;
      cfg_r.near  <= 31'd65536;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CAMERA_X:       cfg_r.cam_x <= cfg_wdata;
        CFG_CAMERA_Y:       cfg_r.cam_y <= cfg_wdata;
        CFG_CAMERA_Z:       cfg_r.cam_z <= cfg_wdata;
        CFG_HEADING_SINE:   cfg_r.hs    <= cfg_wdata[15:0];
        CFG_HEADING_COSINE: cfg_r.hc    <= cfg_wdata[15:0];
        CFG_PITCH_SINE:     cfg_r.ps    <= cfg_wdata[15:0];
        CFG_PITCH_COSINE:   cfg_r.pc    <= cfg_wdata[15:0];
        CFG_NEAR_DISTANCE:  cfg_r.near  <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  vvt_rotate u_rotate (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .vx       (in_vertex_x),
    .vy       (in_vertex_y),
    .vz       (in_vertex_z),
    .cfg      (cfg_r),
    .valid    (rot_valid),
    .rx       (rot_rx),
    .fy       (rot_fy),
    .fz       (rot_fz)
  );

  vvt_setup u_setup (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (rot_valid),
    .rx       (rot_rx),
    .fy       (rot_fy),
    .fz       (rot_fz),
    .near     (cfg_r.near),
    .valid    (set_valid),
    .den      (set_den),
    .lane_x   (set_lx),
    .lane_y   (set_ly),
    .side     (set_side)
  );

  vvt_divide u_divide (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (set_valid),
    .den      (set_den),
    .lane_x   (set_lx),
    .lane_y   (set_ly),
    .side     (set_side),
    .valid    (div_valid),
    .quot_x   (div_qx),
    .quot_y   (div_qy),
    .flags_x  (div_fx),
    .flags_y  (div_fy),
    .side_out (div_side)
  );

  // Apply the sign, saturate and zero the coordinates of a vertex behind
  // the near plane. A quotient magnitude of 2^15 or more saturates.
  always_comb begin
    if (div_side.behind) begin
      sx_nxt = '0;
    end else if (div_fx.sat) begin
      sx_nxt = div_fx.neg ? SCREEN_MIN : SCREEN_MAX;
    end else if (div_fx.neg) begin
      sx_nxt = -$signed({1'b0, div_qx});
    end else begin
      sx_nxt = $signed({1'b0, div_qx});
    end
    if (div_side.behind) begin
      sy_nxt = '0;
    end else if (div_fy.sat) begin
      sy_nxt = div_fy.neg ? SCREEN_MIN : SCREEN_MAX;
    end else if (div_fy.neg) begin
      sy_nxt = -$signed({1'b0, div_qy});
    end else begin
      sy_nxt = $signed({1'b0, div_qy});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx_r     <= sx_nxt;
      sy_r     <= sy_nxt;
      depth_r  <= div_side.depth;
      behind_r <= div_side.behind;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_screen_x    = sx_r;
  assign out_screen_y    = sy_r;
  assign out_view_depth  = depth_r;
  assign out_behind_near = behind_r;

endmodule
`default_nettype wire

@@ hw/rtl/vvt_rotate.sv @@
// Camera translation and the two rotations, five register stages.
// Depends on vvt_pkg.
`default_nettype none
module vvt_rotate
  import vvt_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    en,
  input  wire logic                    in_valid,
  input  wire logic signed [31:0]      vx,
  input  wire logic signed [31:0]      vy,
  input  wire logic signed [31:0]      vz,
  input  wire cam_cfg_t                cfg,
  output logic                         valid,
  output logic signed [ROT_W-1:0]      rx,
  output logic signed [FIN_W-1:0]      fy,
  output logic signed [FIN_W-1:0]      fz
);

  logic [4:0] v_r, v_nxt;

  logic signed [DIFF_W-1:0] dx_r, dy_r, dz_r, dz2_r, dz3_r;
  logic signed [48:0] pa_r, pb_r, pc_r, pd_r;
  logic signed [49:0] rx_sum, ry_sum;
  logic signed [ROT_W-1:0] rx3_r, ry3_r, rx4_r, rx5_r;
  logic signed [51:0] qa_r, qd_r;
  logic signed [48:0] qb_r, qc_r;
  logic signed [52:0] fy_sum, fz_sum;
  logic signed [FIN_W-1:0] fy5_r, fz5_r;

  assign v_nxt  = {v_r[3:0], in_valid};
  assign rx_sum = 50'(pa_r) - 50'(pb_r);
  assign ry_sum = 50'(pc_r) + 50'(pd_r);
  assign fy_sum = 53'(qa_r) + 53'(qb_r);
  assign fz_sum = 53'(qc_r) - 53'(qd_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r  <= DIFF_W'(vx) - DIFF_W'(cfg.cam_x);
      dy_r  <= DIFF_W'(vy) - DIFF_W'(cfg.cam_y);
      dz_r  <= DIFF_W'(vz) - DIFF_W'(cfg.cam_z);
      pa_r  <= dx_r * cfg.hs;
      pb_r  <= dy_r * cfg.hc;
      pc_r  <= dy_r * cfg.hs;
      pd_r  <= dx_r * cfg.hc;
      dz2_r <= dz_r;
      // Arithmetic right shift rounds toward minus infinity.
      rx3_r <= ROT_W'(rx_sum >>> FRAC_BITS);
      ry3_r <= ROT_W'(ry_sum >>> FRAC_BITS);
      dz3_r <= dz2_r;
      qa_r  <= ry3_r * cfg.pc;
      qb_r  <= dz3_r * cfg.ps;
      qc_r  <= dz3_r * cfg.pc;
      qd_r  <= ry3_r * cfg.ps;
      rx4_r <= rx3_r;
      fy5_r <= FIN_W'(fy_sum >>> FRAC_BITS);
      fz5_r <= FIN_W'(fz_sum >>> FRAC_BITS);
      rx5_r <= rx4_r;
    end
  end

  assign valid = v_r[4];
  assign rx    = rx5_r;
  assign fy    = fy5_r;
  assign fz    = fz5_r;

endmodule
`default_nettype wire

@@ hw/rtl/vvt_setup.sv @@
// Near-plane test, depth saturation and projection numerators, then the
// sign split and range check ahead of the divider. Depends on vvt_pkg.
`default_nettype none
module vvt_setup
  import vvt_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    en,
  input  wire logic                    in_valid,
  input  wire logic signed [ROT_W-1:0] rx,
  input  wire logic signed [FIN_W-1:0] fy,
  input  wire logic signed [FIN_W-1:0] fz,
  input  wire logic [30:0]             near,
  output logic                         valid,
  output logic [DEN_W-1:0]             den,
  output div_lane_t                    lane_x,
  output div_lane_t                    lane_y,
  output vtx_side_t                    side
);

  logic [1:0] v_r;
  logic signed [NUM_W-1:0] nx_r, ny_r;
  logic [DEN_W-1:0] den6_r, den7_r;
  vtx_side_t side6_r, side7_r, side_nxt;
  div_lane_t lx_r, ly_r;
  logic depth_ovf;
  logic [NUM_W-1:0] mag_x, mag_y, den_top;

  // Depth is out of 32-bit range when the bits above bit 31 disagree with it.
  assign depth_ovf = (fy[FIN_W-1:31] != {(FIN_W-31){fy[31]}});

  always_comb begin
    side_nxt.behind = (fy < $signed({8'd0, near})) || (fy == '0);
    if (!depth_ovf) begin
      side_nxt.depth = fy[31:0];
    end else if (fy[FIN_W-1]) begin
      side_nxt.depth = DEPTH_MIN;
    end else begin
      side_nxt.depth = DEPTH_MAX;
    end
  end

  assign mag_x   = nx_r[NUM_W-1] ? NUM_W'(-nx_r) : NUM_W'(nx_r);
  assign mag_y   = ny_r[NUM_W-1] ? NUM_W'(-ny_r) : NUM_W'(ny_r);
  assign den_top = NUM_W'(den6_r) << Q_BITS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx_r    <= NUM_W'(fy) * SCR_W_N + NUM_W'(rx) * SCR_2W_N;
      ny_r    <= NUM_W'(fy) * SCR_H_N - NUM_W'(fz) * SCR_2W_N;
      den6_r  <= {fy[FIN_W-2:0], 1'b0};
      side6_r <= side_nxt;
      lx_r    <= '{neg: nx_r[NUM_W-1], sat: (mag_x >= den_top), rem: mag_x};
      ly_r    <= '{neg: ny_r[NUM_W-1], sat: (mag_y >= den_top), rem: mag_y};
      den7_r  <= den6_r;
      side7_r <= side6_r;
    end
  end

  assign valid  = v_r[1];
  assign den    = den7_r;
  assign lane_x = lx_r;
  assign lane_y = ly_r;
  assign side   = side7_r;

endmodule
`default_nettype wire

@@ hw/rtl/vvt_divide.sv @@
// Restoring division of both numerators by the shared divisor, twice the
// depth, one quotient bit per register stage. Depends on vvt_pkg.
`default_nettype none
module vvt_divide
  import vvt_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire logic [DEN_W-1:0] den,
  input  wire div_lane_t        lane_x,
  input  wire div_lane_t        lane_y,
  input  wire vtx_side_t        side,
  output logic                  valid,
  output logic [Q_BITS-1:0]     quot_x,
  output logic [Q_BITS-1:0]     quot_y,
  output div_lane_t             flags_x,
  output div_lane_t             flags_y,
  output vtx_side_t             side_out
);

  logic [Q_BITS:0]      v_r;
  logic [DEN_W-1:0]     den_r  [Q_BITS+1];
  div_lane_t            lx_r   [Q_BITS+1];
  div_lane_t            ly_r   [Q_BITS+1];
  logic [Q_BITS-1:0]    qx_r   [Q_BITS+1];
  logic [Q_BITS-1:0]    qy_r   [Q_BITS+1];
  vtx_side_t            side_r [Q_BITS+1];

  // Stage 0 is the incoming item, no register of its own.
  assign v_r[0]    = in_valid;
  assign den_r[0]  = den;
  assign lx_r[0]   = lane_x;
  assign ly_r[0]   = lane_y;
  assign qx_r[0]   = '0;
  assign qy_r[0]   = '0;
  assign side_r[0] = side;

  for (genvar k = 0; k < Q_BITS; k++) begin : g_step
    localparam int SHIFT = Q_BITS - 1 - k;
    logic [NUM_W-1:0] trial;
    logic             bit_x, bit_y;
    div_lane_t        lx_nxt, ly_nxt;

    assign trial = NUM_W'(den_r[k]) << SHIFT;
    assign bit_x = (lx_r[k].rem >= trial);
    assign bit_y = (ly_r[k].rem >= trial);

    always_comb begin
      lx_nxt = lx_r[k];
      ly_nxt = ly_r[k];
      if (bit_x) begin
        lx_nxt.rem = lx_r[k].rem - trial;
      end
      if (bit_y) begin
        ly_nxt.rem = ly_r[k].rem - trial;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k+1]  <= den_r[k];
        lx_r[k+1]   <= lx_nxt;
        ly_r[k+1]   <= ly_nxt;
        qx_r[k+1]   <= {qx_r[k][Q_BITS-2:0], bit_x};
        qy_r[k+1]   <= {qy_r[k][Q_BITS-2:0], bit_y};
        side_r[k+1] <= side_r[k];
      end
    end
  end

  assign valid    = v_r[Q_BITS];
  assign quot_x   = qx_r[Q_BITS];
  assign quot_y   = qy_r[Q_BITS];
  assign flags_x  = lx_r[Q_BITS];
  assign flags_y  = ly_r[Q_BITS];
  assign side_out = side_r[Q_BITS];

endmodule
`default_nettype wire

@@ hw/rtl/vvt_checker.sv @@
// Port-level checks of the vertex view transform, bound to the top level.
// Depends on vertex_view_transform_project_assert.svh.
`default_nettype none
`include "vertex_view_transform_project_assert.svh"
module vvt_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [15:0] out_screen_x,
  input wire logic signed [15:0] out_screen_y,
  input wire logic signed [31:0] out_view_depth,
  input wire logic               out_behind_near
);

  // A stalled result stays valid and keeps its coordinates and depth.
  `VVT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_screen_x) && $stable(out_screen_y) && $stable(out_view_depth), "stalled result changed")

  // A vertex behind the near plane reports zero coordinates.
  `VVT_ASSERT_SAME(a_behind_zero, out_valid && out_behind_near, out_screen_x == 16'sd0 && out_screen_y == 16'sd0, "behind vertex has coordinates")

  // A projected vertex always has a positive depth.
  `VVT_ASSERT_SAME(a_depth_pos, out_valid && !out_behind_near, !out_view_depth[31] && out_view_depth != 32'sd0, "projected vertex with non-positive depth")

  // An empty output slot never blocks the input.
  `VVT_ASSERT_SAME(a_ready_free, !out_valid, in_ready, "input blocked with empty output")

  // Reset leaves no result behind.
  `VVT_ASSERT_ALWAYS(a_reset_empty, $past(!rst_n), !out_valid, "result present after reset")

endmodule

bind vertex_view_transform_project vvt_checker u_vvt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_screen_x    (out_screen_x),
  .out_screen_y    (out_screen_y),
  .out_view_depth  (out_view_depth),
  .out_behind_near (out_behind_near)
);
`default_nettype wire
